### src/zsrld_pkg.sv
// ----------------------------------------------------------------------------
// zsrld_pkg
// Shared types and constants of the zero-skip run-length decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package zsrld_pkg;

  localparam int MAX_FRAME_BYTES = 65536;
  localparam int OFFSET_SPAN     = 65536;
  localparam int LIMIT_CAP       = (MAX_FRAME_BYTES < OFFSET_SPAN) ?
                                   MAX_FRAME_BYTES : OFFSET_SPAN;

  localparam int BYTE_W     = 8;
  localparam int COUNT_W    = 17;
  localparam int OFFSET_W   = 17;
  localparam int START_W    = 16;
  localparam int IDX_W      = 3;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 17;

  localparam logic [COUNT_W-1:0]    ACCUM_MAX     = 17'h1FFFF;
  localparam logic [OFFSET_W-1:0]   LIMIT_CAP_V   = OFFSET_W'(LIMIT_CAP);
  localparam logic [CFG_DATA_W-1:0] FRAME_RST     = CFG_DATA_W'(65536);
  localparam logic [IDX_W-1:0]      IDX_MAX       = 3'd7;
  localparam logic [BYTE_W-1:0]     OP_ZERO       = 8'h00;
  localparam logic [BYTE_W-1:0]     OP_SKIP       = 8'h01;
  localparam logic [BYTE_W-1:0]     PAYLOAD_MASK  = 8'h7F;
  localparam logic [BYTE_W-1:0]     CONT_MASK     = 8'h80;

  localparam logic [CFG_ADDR_W-1:0] REG_LENGTH_FORMAT = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_BYTES   = 1'd1;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    PH_IDLE   = 2'b01,
    PH_LENGTH = 2'b10
  } phase_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_LIT,
    CMD_ZERO,
    CMD_SKIP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [COUNT_W-1:0] count;
    logic [BYTE_W-1:0]  fill;
    logic               last;
    logic               trunc;
  } cmd_t;

endpackage

`default_nettype wire

### src/zsrld_if.sv
// ----------------------------------------------------------------------------
// zsrld_in_if / zsrld_out_if
// Valid/ready channels carrying compressed bytes in and run descriptors out.
// ----------------------------------------------------------------------------
`default_nettype none

interface zsrld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       last_in_frame;

  modport source (output valid, output code_byte, output last_in_frame, input ready);
  modport sink   (input valid, input code_byte, input last_in_frame, output ready);
endinterface

interface zsrld_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] start_offset;
  logic [16:0] run_count;
  logic [7:0]  fill_value;
  logic        frame_end;
  logic        overflow;

  modport source (output valid, output start_offset, output run_count,
                  output fill_value, output frame_end, output overflow, input ready);
  modport sink   (input valid, input start_offset, input run_count,
                  input fill_value, input frame_end, input overflow, output ready);
endinterface

`default_nettype wire

### src/zero_skip_run_length_decoder_top.sv
// ----------------------------------------------------------------------------
// zero_skip_run_length_decoder_top
// Zero-skip run-length decoder with varint or two-byte run lengths.
// ----------------------------------------------------------------------------
// Takes one compressed byte per clock while the command queue has room and
// turns literals, zero runs and skips into write descriptors (start, count,
// value); the byte flagged as last in the frame always yields a descriptor
// with frame_end set and then the decoder returns to its reset state. The
// parser front end and the run executor are separated by a two-entry
// command queue, and results leave through an output register, so a byte
// can be taken every cycle while the queue is not full. A descriptor passes
// through the command queue and then the output register before it is
// presented. The pace is set by the clip-and-advance step on the write
// offset in the executor. Configuration writes must only be made while no
// transaction is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module zero_skip_run_length_decoder_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [zsrld_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [zsrld_pkg::CFG_DATA_W-1:0]  cfg_data,
  zsrld_in_if.sink                               in_if,
  zsrld_out_if.source                            out_if
);

  logic                              length_format_r;
  logic [zsrld_pkg::CFG_DATA_W-1:0]  frame_bytes_r;

  logic            in_accept;
  logic            cmd_push;
  zsrld_pkg::cmd_t cmd_in;
  zsrld_pkg::cmd_t cmd_out;
  logic            q_full;
  logic            q_not_empty;
  logic            q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_format_r <= 1'b0;
      frame_bytes_r   <= zsrld_pkg::FRAME_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        zsrld_pkg::REG_LENGTH_FORMAT: length_format_r <= cfg_data[0];
        zsrld_pkg::REG_FRAME_BYTES:   frame_bytes_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_if.ready = !q_full;
  assign in_accept   = in_if.valid && !q_full;

  zsrld_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .length_format (length_format_r),
    .in_accept     (in_accept),
    .in_byte       (in_if.code_byte),
    .in_last       (in_if.last_in_frame),
    .cmd_push      (cmd_push),
    .cmd           (cmd_in)
  );

  zsrld_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (cmd_out)
  );

  zsrld_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .frame_bytes (frame_bytes_r),
    .cmd_valid   (q_not_empty),
    .cmd         (cmd_out),
    .cmd_pop     (q_pop),
    .out_if      (out_if)
  );

endmodule

`default_nettype wire

### src/zsrld_front.sv
// ----------------------------------------------------------------------------
// zsrld_front
// Parses the byte stream into literal, zero-run, skip and end commands.
// ----------------------------------------------------------------------------
`default_nettype none

module zsrld_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          length_format,
  input  wire logic                          in_accept,
  input  wire logic [zsrld_pkg::BYTE_W-1:0]  in_byte,
  input  wire logic                          in_last,
  output      logic                          cmd_push,
  output      zsrld_pkg::cmd_t               cmd
);

  zsrld_pkg::phase_t                   phase_r, phase_nxt;
  logic                                skip_r, skip_nxt;
  logic [zsrld_pkg::COUNT_W-1:0]       accum_r, accum_nxt;
  logic [zsrld_pkg::IDX_W-1:0]         idx_r, idx_nxt;

  logic [zsrld_pkg::COUNT_W-1:0]       accum_new;
  logic                                done;
  logic [6:0]                          pay;
  logic [23:0]                         shl;
  logic [23:0]                         merged;

  // varint payload placed at its 7-bit group
  always_comb begin
    pay = in_byte[6:0] & zsrld_pkg::PAYLOAD_MASK[6:0];
    case (idx_r)
      3'd0:    shl = {17'd0, pay};
      3'd1:    shl = {10'd0, pay, 7'd0};
      3'd2:    shl = {3'd0, pay, 14'd0};
      default: shl = '0;
    endcase
    merged = {7'd0, accum_r} | shl;
  end

  always_comb begin
    if (length_format) begin
      if (idx_r == '0) begin
        accum_new = {9'd0, in_byte};
      end else begin
        accum_new = accum_r | {1'b0, in_byte, 8'd0};
      end
      done = (idx_r != '0);
    end else begin
      if (idx_r >= 3'd3) begin
        accum_new = (pay != '0) ? zsrld_pkg::ACCUM_MAX : accum_r;
      end else begin
        accum_new = (|merged[23:17]) ? zsrld_pkg::ACCUM_MAX : merged[16:0];
      end
      done = ((in_byte & zsrld_pkg::CONT_MASK) == '0);
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    skip_nxt  = skip_r;
    accum_nxt = accum_r;
    idx_nxt   = idx_r;
    cmd       = '{kind: zsrld_pkg::CMD_NONE, count: '0, fill: '0, last: 1'b0, trunc: 1'b0};
    cmd_push  = 1'b0;
    if (in_accept) begin
      if (phase_r == zsrld_pkg::PH_IDLE) begin
        if (in_byte == zsrld_pkg::OP_ZERO || in_byte == zsrld_pkg::OP_SKIP) begin
          skip_nxt  = (in_byte == zsrld_pkg::OP_SKIP);
          accum_nxt = '0;
          idx_nxt   = '0;
          phase_nxt = zsrld_pkg::PH_LENGTH;
        end else begin
          cmd.kind  = zsrld_pkg::CMD_LIT;
          cmd.count = zsrld_pkg::COUNT_W'(1);
          cmd.fill  = in_byte;
          cmd_push  = 1'b1;
        end
      end else begin
        idx_nxt = (idx_r < zsrld_pkg::IDX_MAX) ? idx_r + 3'd1 : idx_r;
        if (done) begin
          cmd.kind  = skip_r ? zsrld_pkg::CMD_SKIP : zsrld_pkg::CMD_ZERO;
          cmd.count = accum_new;
          cmd_push  = 1'b1;
          phase_nxt = zsrld_pkg::PH_IDLE;
          accum_nxt = '0;
          idx_nxt   = '0;
          skip_nxt  = 1'b0;
        end else begin
          accum_nxt = accum_new;
        end
      end
      if (in_last) begin
        // a run still waiting for its length is dropped
        cmd.last  = 1'b1;
        cmd.trunc = (phase_nxt != zsrld_pkg::PH_IDLE);
        cmd_push  = 1'b1;
        phase_nxt = zsrld_pkg::PH_IDLE;
        accum_nxt = '0;
        idx_nxt   = '0;
        skip_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= zsrld_pkg::PH_IDLE;
      skip_r  <= 1'b0;
      accum_r <= '0;
      idx_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      skip_r  <= skip_nxt;
      accum_r <= accum_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

`default_nettype wire

### src/zsrld_fifo.sv
// ----------------------------------------------------------------------------
// zsrld_fifo
// Short command queue between the parser and the run executor.
// ----------------------------------------------------------------------------
`default_nettype none

module zsrld_fifo (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire zsrld_pkg::cmd_t push_data,
  output      logic            full,
  input  wire logic            pop,
  output      logic            not_empty,
  output      zsrld_pkg::cmd_t pop_data
);

  zsrld_pkg::cmd_t                    slot_r [zsrld_pkg::FIFO_DEPTH];
  logic [zsrld_pkg::FIFO_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [zsrld_pkg::FIFO_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [zsrld_pkg::FIFO_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                               do_push, do_pop;

  assign full      = (cnt_r == zsrld_pkg::FIFO_CNT_W'(zsrld_pkg::FIFO_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_data  = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == zsrld_pkg::FIFO_PTR_W'(zsrld_pkg::FIFO_DEPTH - 1)) ?
                   '0 : wr_ptr_r + zsrld_pkg::FIFO_PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == zsrld_pkg::FIFO_PTR_W'(zsrld_pkg::FIFO_DEPTH - 1)) ?
                   '0 : rd_ptr_r + zsrld_pkg::FIFO_PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + zsrld_pkg::FIFO_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - zsrld_pkg::FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

### src/zsrld_back.sv
// ----------------------------------------------------------------------------
// zsrld_back
// Executes commands: clips to the frame size, tracks the write offset and
// presents run descriptors through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module zsrld_back (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic [zsrld_pkg::CFG_DATA_W-1:0]  frame_bytes,
  input  wire logic                              cmd_valid,
  input  wire zsrld_pkg::cmd_t                   cmd,
  output      logic                              cmd_pop,
  zsrld_out_if.source                            out_if
);

  logic [zsrld_pkg::OFFSET_W-1:0] offset_r, offset_nxt;
  logic                           ovf_r, ovf_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [zsrld_pkg::START_W-1:0]  start_r;
  logic [zsrld_pkg::COUNT_W-1:0]  count_r;
  logic [zsrld_pkg::BYTE_W-1:0]   fill_r;
  logic                           end_r;
  logic                           oflag_r;

  logic [zsrld_pkg::OFFSET_W-1:0] limit;
  logic [zsrld_pkg::OFFSET_W-1:0] room;
  logic                           clipped;
  logic [zsrld_pkg::COUNT_W-1:0]  take;
  logic [zsrld_pkg::OFFSET_W-1:0] new_off;
  logic [zsrld_pkg::OFFSET_W-1:0] run_start;
  logic                           makes_result;
  logic                           slot_free;
  logic                           load_out;

  always_comb begin
    if (frame_bytes == '0 || frame_bytes > zsrld_pkg::LIMIT_CAP_V) begin
      limit = zsrld_pkg::LIMIT_CAP_V;
    end else begin
      limit = frame_bytes;
    end
    room    = (offset_r >= limit) ? '0 : limit - offset_r;
    clipped = (cmd.count > room);
    take    = clipped ? room : cmd.count;
    new_off = offset_r + take;
  end

  assign makes_result = (cmd.kind == zsrld_pkg::CMD_LIT) ||
                        (cmd.kind == zsrld_pkg::CMD_ZERO) || cmd.last;
  assign slot_free    = !out_valid_r || out_if.ready;
  // a skip inside the frame moves the offset without needing the output slot
  assign cmd_pop      = cmd_valid && (slot_free || !makes_result);
  assign load_out     = cmd_pop && makes_result;
  assign run_start    = (cmd.kind == zsrld_pkg::CMD_LIT || cmd.kind == zsrld_pkg::CMD_ZERO) ?
                        offset_r : new_off;

  always_comb begin
    offset_nxt    = offset_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
    if (cmd_pop) begin
      if (cmd.last) begin
        offset_nxt = '0;
        ovf_nxt    = 1'b0;
      end else begin
        offset_nxt = new_off;
        ovf_nxt    = ovf_r | clipped;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      start_r <= run_start[zsrld_pkg::OFFSET_W-1] ? '1 : run_start[zsrld_pkg::START_W-1:0];
      count_r <= (cmd.kind == zsrld_pkg::CMD_SKIP) ? '0 : take;
      fill_r  <= cmd.fill;
      end_r   <= cmd.last;
      oflag_r <= ovf_r | clipped | cmd.trunc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r    <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      offset_r    <= offset_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.start_offset = start_r;
  assign out_if.run_count    = count_r;
  assign out_if.fill_value   = fill_r;
  assign out_if.frame_end    = end_r;
  assign out_if.overflow     = oflag_r;

endmodule

`default_nettype wire

### test/tb_zero_skip_run_length_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_zero_skip_run_length_decoder_top
// Self-checking bench for the zero-skip run-length decoder.
// ----------------------------------------------------------------------------
// Feeds compressed frames byte by byte: literals, zero runs, skips, long and
// oversized varints, two-byte lengths and frames cut inside a length. A
// scoreboard decodes every accepted byte on its own and compares each run
// descriptor field by field. Both channels idle at random, the result side
// is held off for a long stretch once, and several frame-size and
// length-format settings are covered, the extremes among them.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [zsrld_pkg::START_W-1:0] start_offset;
  logic [zsrld_pkg::COUNT_W-1:0] run_count;
  logic [zsrld_pkg::BYTE_W-1:0]  fill_value;
  logic                          frame_end;
  logic                          overflow;
} run_desc_t;

class run_scoreboard;
  bit                               two_byte_len;
  logic [zsrld_pkg::CFG_DATA_W-1:0] frame_size;
  zsrld_pkg::phase_t                phase;
  bit                               skip_run;
  logic [zsrld_pkg::COUNT_W-1:0]    accum;
  logic [zsrld_pkg::IDX_W-1:0]      len_idx;
  logic [zsrld_pkg::OFFSET_W-1:0]   offset;
  bit                               overflow_seen;
  run_desc_t                        runs_due[$];
  int unsigned                      errors;
  int unsigned                      checked;
  int unsigned                      frames;

  function new();
    two_byte_len = 1'b0;
    frame_size   = zsrld_pkg::FRAME_RST;
    errors       = 0;
    checked      = 0;
    frames       = 0;
    clear_frame();
  endfunction

  function void clear_frame();
    phase         = zsrld_pkg::PH_IDLE;
    skip_run      = 1'b0;
    accum         = '0;
    len_idx       = '0;
    offset        = '0;
    overflow_seen = 1'b0;
  endfunction

  function void set_register(logic [zsrld_pkg::CFG_ADDR_W-1:0] idx,
                             logic [zsrld_pkg::CFG_DATA_W-1:0] data);
    if (idx == zsrld_pkg::REG_LENGTH_FORMAT) begin
      two_byte_len = data[0];
    end else if (idx == zsrld_pkg::REG_FRAME_BYTES) begin
      frame_size = data;
    end
  endfunction

  // cut a request to the room left in the frame, flag it if cut
  function int unsigned clip_to_room(int unsigned want);
    int unsigned lim;
    int unsigned room;
    lim  = (frame_size == 0 || frame_size > zsrld_pkg::LIMIT_CAP) ?
           zsrld_pkg::LIMIT_CAP : frame_size;
    room = (offset >= lim) ? 0 : lim - offset;
    if (want > room) begin
      overflow_seen = 1'b1;
      return room;
    end
    return want;
  endfunction

  function void note_byte(logic [7:0] b, logic last);
    bit          emit;
    bit          done;
    int unsigned start;
    int unsigned count;
    int unsigned pay;
    int unsigned v;
    logic [7:0]  fill;
    run_desc_t   d;
    emit  = 1'b0;
    done  = 1'b0;
    start = 0;
    count = 0;
    fill  = '0;
    if (phase == zsrld_pkg::PH_IDLE) begin
      if (b == zsrld_pkg::OP_ZERO || b == zsrld_pkg::OP_SKIP) begin
        skip_run = (b == zsrld_pkg::OP_SKIP);
        accum    = '0;
        len_idx  = '0;
        phase    = zsrld_pkg::PH_LENGTH;
      end else begin
        start  = offset;
        count  = clip_to_room(1);
        fill   = b;
        offset = offset + zsrld_pkg::OFFSET_W'(count);
        emit   = 1'b1;
      end
    end else begin
      if (two_byte_len) begin
        if (len_idx == 0) accum = zsrld_pkg::COUNT_W'(b);
        else accum = accum | (zsrld_pkg::COUNT_W'(b) << 8);
        done = (len_idx != 0);
      end else begin
        pay = b & zsrld_pkg::PAYLOAD_MASK;
        // past the third byte only a non-zero payload matters: saturate
        if (len_idx >= 3) begin
          if (pay != 0) accum = zsrld_pkg::ACCUM_MAX;
        end else begin
          v     = accum | (pay << (7 * len_idx));
          accum = (v > zsrld_pkg::ACCUM_MAX) ? zsrld_pkg::ACCUM_MAX : zsrld_pkg::COUNT_W'(v);
        end
        done = ((b & zsrld_pkg::CONT_MASK) == 0);
      end
      if (len_idx < zsrld_pkg::IDX_MAX) len_idx++;
      if (done) begin
        start  = offset;
        count  = clip_to_room(accum);
        offset = offset + zsrld_pkg::OFFSET_W'(count);
        if (skip_run) count = 0;
        else emit = 1'b1;
        phase    = zsrld_pkg::PH_IDLE;
        accum    = '0;
        len_idx  = '0;
        skip_run = 1'b0;
      end
    end

    if (last) begin
      // a length left open at frame end is dropped
      if (phase != zsrld_pkg::PH_IDLE) overflow_seen = 1'b1;
      if (!emit) begin
        start = offset;
        count = 0;
        fill  = '0;
      end
      emit = 1'b1;
    end

    if (emit) begin
      d.start_offset = (start > 65535) ? 16'hFFFF : zsrld_pkg::START_W'(start);
      d.run_count    = zsrld_pkg::COUNT_W'(count);
      d.fill_value   = fill;
      d.frame_end    = last;
      d.overflow     = overflow_seen;
      runs_due.push_back(d);
    end
    if (last) begin
      frames++;
      clear_frame();
    end
  endfunction

  function void field_ok(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      errors++;
    end
  endfunction

  function void check_result(run_desc_t got);
    run_desc_t want;
    if (runs_due.size() == 0) begin
      $display("%0t: unexpected run descriptor, expected none, actual %p", $time, got);
      errors++;
      return;
    end
    want = runs_due.pop_front();
    checked++;
    field_ok("start_offset", want.start_offset, got.start_offset);
    field_ok("run_count",    want.run_count,    got.run_count);
    field_ok("fill_value",   want.fill_value,   got.fill_value);
    field_ok("frame_end",    want.frame_end,    got.frame_end);
    field_ok("overflow",     want.overflow,     got.overflow);
  endfunction
endclass

module tb_zero_skip_run_length_decoder_top;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          SETTLE_CYCLES = 8;
  localparam int unsigned RANDOM_BYTES  = 1300;
  localparam int unsigned PHASE_BYTES   = 160;

  logic                             clk = 1'b0;
  logic                             rst_n;
  logic                             cfg_we;
  logic [zsrld_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [zsrld_pkg::CFG_DATA_W-1:0] cfg_data;

  zsrld_in_if  in_if ();
  zsrld_out_if out_if ();

  zero_skip_run_length_decoder_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .in_if    (in_if),
    .out_if   (out_if)
  );

  run_scoreboard sb = new();

  logic [7:0]  frame_q[$];
  bit          two_byte_len   = 1'b0;
  bit          hold_sink      = 1'b0;
  int unsigned src_idle_pct   = 31;
  int unsigned sink_idle_pct  = 31;
  int unsigned bytes_sent     = 0;
  int unsigned settings_used  = 0;
  int unsigned cycle_count    = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // monitor: both channels sampled at the clock edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        sb.note_byte(in_if.code_byte, in_if.last_in_frame);
      end
      if (out_if.valid && out_if.ready) begin
        sb.check_result('{out_if.start_offset, out_if.run_count, out_if.fill_value,
                          out_if.frame_end, out_if.overflow});
      end
    end
  end

  // result side: random back-pressure, plus one long hold-off on request
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_sink) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_sink = 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.code_byte     <= b;
    in_if.last_in_frame <= last;
    do @(posedge clk); while (!in_if.ready);
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
  endtask

  // wait for every descriptor, then let skips and opcodes still in flight settle
  task automatic drain_and_settle();
    in_if.valid <= 1'b0;
    while (sb.runs_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_setting(input bit fmt, input logic [zsrld_pkg::CFG_DATA_W-1:0] size);
    cfg_we   <= 1'b1;
    cfg_addr <= zsrld_pkg::REG_LENGTH_FORMAT;
    cfg_data <= zsrld_pkg::CFG_DATA_W'(fmt);
    @(posedge clk);
    cfg_addr <= zsrld_pkg::REG_FRAME_BYTES;
    cfg_data <= size;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_register(zsrld_pkg::REG_LENGTH_FORMAT, zsrld_pkg::CFG_DATA_W'(fmt));
    sb.set_register(zsrld_pkg::REG_FRAME_BYTES, size);
    two_byte_len = fmt;
    settings_used++;
  endtask

  function automatic int unsigned pick_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return $urandom_range(8);
    if (r < 80) return $urandom_range(200, 9);
    if (r < 92) return $urandom_range(5000, 201);
    return $urandom_range(zsrld_pkg::ACCUM_MAX, 5001);
  endfunction

  function automatic void push_length(int unsigned n);
    if (two_byte_len) begin
      frame_q.push_back(n[7:0]);
      frame_q.push_back(n[15:8]);
    end else begin
      do begin
        frame_q.push_back({(n > 127), n[6:0]});
        n = n >> 7;
      end while (n != 0);
    end
  endfunction

  function automatic void push_token();
    int unsigned r;
    int unsigned k;
    r = $urandom_range(99);
    if (r < 45) begin
      frame_q.push_back(8'($urandom_range(255, 2)));
    end else if (r < 65) begin
      frame_q.push_back(zsrld_pkg::OP_ZERO);
      push_length(pick_length());
    end else if (r < 80) begin
      frame_q.push_back(zsrld_pkg::OP_SKIP);
      push_length(pick_length());
    end else if (r < 88 && !two_byte_len) begin
      // varint running past three bytes, payloads random
      frame_q.push_back(r[0] ? zsrld_pkg::OP_ZERO : zsrld_pkg::OP_SKIP);
      k = $urandom_range(9, 4);
      repeat (k - 1) frame_q.push_back(8'(zsrld_pkg::CONT_MASK | $urandom_range(127)));
      frame_q.push_back(8'($urandom_range(127)));
    end else begin
      repeat ($urandom_range(3, 1)) frame_q.push_back(8'($urandom_range(255)));
    end
  endfunction

  function automatic void build_frame();
    frame_q.delete();
    repeat ($urandom_range(10, 1)) push_token();
    // now and then the frame stops inside a run length
    if ($urandom_range(99) < 10) begin
      frame_q.push_back($urandom_range(1) ? zsrld_pkg::OP_ZERO : zsrld_pkg::OP_SKIP);
      if (two_byte_len) begin
        if ($urandom_range(1)) frame_q.push_back(8'($urandom_range(255)));
      end else begin
        repeat ($urandom_range(2)) begin
          frame_q.push_back(8'(zsrld_pkg::CONT_MASK | $urandom_range(127)));
        end
      end
    end
  endfunction

  initial begin
    int unsigned                      phase_idx;
    int unsigned                      phase_start;
    int unsigned                      random_start;
    int unsigned                      phase_frames;
    bit                               fmt;
    logic [zsrld_pkg::CFG_DATA_W-1:0] size;

    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_addr            <= zsrld_pkg::REG_LENGTH_FORMAT;
    cfg_data            <= '0;
    in_if.valid         <= 1'b0;
    in_if.code_byte     <= '0;
    in_if.last_in_frame <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: varint lengths, full frame size
    frame_q = {8'h02, 8'hFF, 8'h55, 8'hAA, zsrld_pkg::OP_ZERO, 8'h05,
               zsrld_pkg::OP_ZERO, 8'h00, zsrld_pkg::OP_SKIP, 8'h03,
               zsrld_pkg::OP_SKIP, 8'h00, zsrld_pkg::OP_ZERO, 8'h80, 8'h01};
    send_frame();
    // saturating varint, clipped to the whole frame
    frame_q = {zsrld_pkg::OP_ZERO, 8'hFF, 8'hFF, 8'hFF, 8'h01};
    send_frame();
    // frame ends right on an opcode
    frame_q = {8'h7E, zsrld_pkg::OP_SKIP};
    send_frame();
    drain_and_settle();
    // two-byte lengths, one-byte frame: everything past the first byte clips
    apply_setting(1'b1, 17'd1);
    frame_q = {zsrld_pkg::OP_ZERO, 8'hFF, 8'hFF, 8'h09};
    send_frame();

    random_start = bytes_sent;
    phase_idx    = 0;
    while (bytes_sent - random_start < RANDOM_BYTES) begin
      drain_and_settle();
      fmt = phase_idx[0] ^ phase_idx[2];
      case (phase_idx % 8)
        0: size = 17'd1;
        1: size = 17'd65536;
        2: size = zsrld_pkg::CFG_DATA_W'($urandom_range(64, 2));
        3: size = '0;
        4: size = zsrld_pkg::CFG_DATA_W'($urandom_range(600, 65));
        5: size = 17'h1FFFF;
        6: size = zsrld_pkg::CFG_DATA_W'($urandom_range(65536, 1));
        default: size = 17'd65535;
      endcase
      apply_setting(fmt, size);
      src_idle_pct  = (phase_idx == 4) ? 0 : 31;
      sink_idle_pct = (phase_idx == 4) ? 0 : 31;
      if (phase_idx == 2) hold_sink = 1'b1;
      phase_start  = bytes_sent;
      phase_frames = 0;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        if (phase_idx == 3 && phase_frames == 3) drain_and_settle();
        build_frame();
        send_frame();
        phase_frames++;
      end
      phase_idx++;
    end

    drain_and_settle();
    $display("Covered %0d compressed bytes in %0d frames over %0d register settings;",
             bytes_sent, sb.frames, settings_used);
    $display("%0d run descriptors checked, %0d mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
